// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TESQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TESQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tesq_pkg.sv
// ----------------------------------------------------------------------------
// tesq_pkg
// shared constants and operation codes of the timed event queue
// ----------------------------------------------------------------------------
`default_nettype none

package tesq_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned OVR_W = 16;
  localparam int unsigned OCC_W = 7;

  localparam logic [OVR_W-1:0] OVR_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/core/tesq_in_if.sv
// ----------------------------------------------------------------------------
// tesq_in_if
// request channel: push, tick or clear with its operands
// ----------------------------------------------------------------------------
`default_nettype none

interface tesq_in_if #(
  parameter int unsigned TIME_WIDTH = 40,
  parameter int unsigned TAG_WIDTH  = 16
);
  import tesq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [TIME_WIDTH-1:0] event_time;
  logic [TAG_WIDTH-1:0]  event_tag;
  logic [TIME_WIDTH-1:0] current_time;

  modport source (
    output valid, operation, event_time, event_tag, current_time,
    input  ready
  );

  modport sink (
    input  valid, operation, event_time, event_tag, current_time,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/core/tesq_out_if.sv
// ----------------------------------------------------------------------------
// tesq_out_if
// result channel: fired event, reject flag and queue status
// ----------------------------------------------------------------------------
`default_nettype none

interface tesq_out_if #(
  parameter int unsigned TIME_WIDTH = 40,
  parameter int unsigned TAG_WIDTH  = 16
);
  import tesq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  fired;
  logic [TAG_WIDTH-1:0]  fired_tag;
  logic [TIME_WIDTH-1:0] fired_time;
  logic                  rejected;
  logic [OVR_W-1:0]      overrun_total;
  logic [OCC_W-1:0]      occupancy;

  modport source (
    output valid, fired, fired_tag, fired_time, rejected, overrun_total, occupancy,
    input  ready
  );

  modport sink (
    input  valid, fired, fired_tag, fired_time, rejected, overrun_total, occupancy,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/core/tesq_slot_ram.sv
// ----------------------------------------------------------------------------
// tesq_slot_ram
// slot store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tesq_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/timed_event_sorted_queue.sv
// ----------------------------------------------------------------------------
// timed_event_sorted_queue
// time-ordered ring of scheduled events with push, tick and clear
//
//   channel  dir  handshake          payload
//   ev_i     in   valid / ready      operation, event_time, event_tag, current_time
//   res_o    out  valid / ready      fired, fired_tag, fired_time, rejected,
//                                    overrun_total, occupancy
//
// push: from the tail, ST_SHIFT_RD reads an entry and ST_SHIFT_CMP compares, writes
//   it, one read and one write per entry moved; a full ring goes straight to ST_RESP
// tick: ST_TICK_CMP then ST_RESP, clear and unused codes: ST_RESP, one request at a time
// reset clears head, count and status at once; slot contents need no clearing
// the result waits in an output register; the next request is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_sorted_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TIME_WIDTH  = 40,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tesq_in_if.sink     ev_i,
  tesq_out_if.source  res_o
);
  import tesq_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned ENT_W = TIME_WIDTH + TAG_WIDTH;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_CMP,
    ST_TICK_CMP,
    ST_RESP
  } state_e;

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e                state_q;
  logic [IDX_W-1:0]      head_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CNT_W-1:0]      j_q;
  logic [TIME_WIDTH-1:0] prev_q;
  logic                  fresh_q;
  logic [OVR_W-1:0]      ovr_q;
  logic [TIME_WIDTH-1:0] new_time_q;
  logic [TAG_WIDTH-1:0]  new_tag_q;
  logic [TIME_WIDTH-1:0] now_q;

  logic                  res_fired_q;
  logic [TAG_WIDTH-1:0]  res_tag_q;
  logic [TIME_WIDTH-1:0] res_time_q;
  logic                  res_rej_q;

  logic                  out_valid_q;
  logic                  out_fired_q;
  logic [TAG_WIDTH-1:0]  out_tag_q;
  logic [TIME_WIDTH-1:0] out_time_q;
  logic                  out_rej_q;
  logic [OVR_W-1:0]      out_ovr_q;
  logic [OCC_W-1:0]      out_occ_q;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENT_W-1:0]      mem_rdata;

  logic [TIME_WIDTH-1:0] rd_time;
  logic [TAG_WIDTH-1:0]  rd_tag;
  logic [CNT_W-1:0]      j_m1;
  logic                  shift_later;
  logic [TIME_WIDTH-1:0] limit;
  logic                  fire;

  tesq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_time     = mem_rdata[ENT_W-1:TAG_WIDTH];
  assign rd_tag      = mem_rdata[TAG_WIDTH-1:0];
  assign j_m1        = j_q - 1'b1;
  assign shift_later = rd_time > new_time_q;
  assign limit       = fresh_q ? now_q : prev_q;
  assign fire        = (cnt_q != '0) && (rd_time < limit);

  // head is read every idle cycle so a tick finds it ready
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head_q;
    mem_we    = 1'b0;
    mem_waddr = ring_pos(head_q, j_q);
    mem_wdata = {new_time_q, new_tag_q};
    unique case (state_q)
      ST_IDLE: begin
        mem_re = 1'b1;
      end
      ST_SHIFT_RD: begin
        if (j_q == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ring_pos(head_q, j_m1);
        end
      end
      ST_SHIFT_CMP: begin
        mem_we = 1'b1;
        if (shift_later) begin
          mem_wdata = mem_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      j_q         <= '0;
      prev_q      <= '0;
      fresh_q     <= 1'b1;
      ovr_q       <= '0;
      new_time_q  <= '0;
      new_tag_q   <= '0;
      now_q       <= '0;
      res_fired_q <= 1'b0;
      res_tag_q   <= '0;
      res_time_q  <= '0;
      res_rej_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_fired_q <= 1'b0;
      out_tag_q   <= '0;
      out_time_q  <= '0;
      out_rej_q   <= 1'b0;
      out_ovr_q   <= '0;
      out_occ_q   <= '0;
    end else begin
      if (out_valid_q && res_o.ready && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ev_i.valid) begin
            res_fired_q <= 1'b0;
            res_tag_q   <= '0;
            res_time_q  <= '0;
            res_rej_q   <= (ev_i.operation == OP_PUSH) && (cnt_q == DEPTH_C);
            new_time_q  <= ev_i.event_time;
            new_tag_q   <= ev_i.event_tag;
            now_q       <= ev_i.current_time;
            case (ev_i.operation)
              OP_PUSH: begin
                if (cnt_q == DEPTH_C) begin
                  if (ovr_q != OVR_MAX) begin
                    ovr_q <= ovr_q + 1'b1;
                  end
                  state_q <= ST_RESP;
                end else begin
                  j_q     <= cnt_q;
                  state_q <= ST_SHIFT_RD;
                end
              end
              OP_TICK: begin
                state_q <= ST_TICK_CMP;
              end
              OP_CLEAR: begin
                cnt_q   <= '0;
                head_q  <= '0;
                prev_q  <= '0;
                fresh_q <= 1'b1;
                ovr_q   <= '0;
                state_q <= ST_RESP;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_SHIFT_RD: begin
          if (j_q == '0) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_SHIFT_CMP;
          end
        end
        ST_SHIFT_CMP: begin
          if (shift_later) begin
            j_q     <= j_m1;
            state_q <= ST_SHIFT_RD;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_RESP;
          end
        end
        ST_TICK_CMP: begin
          if (fire) begin
            res_fired_q <= 1'b1;
            res_tag_q   <= rd_tag;
            res_time_q  <= rd_time;
            cnt_q       <= cnt_q - 1'b1;
            head_q      <= ring_pos(head_q, CNT_W'(1));
          end
          prev_q  <= now_q;
          fresh_q <= 1'b0;
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_fired_q <= res_fired_q;
            out_tag_q   <= res_tag_q;
            out_time_q  <= res_time_q;
            out_rej_q   <= res_rej_q;
            out_ovr_q   <= ovr_q;
            out_occ_q   <= OCC_W'(cnt_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ev_i.ready          = (state_q == ST_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.fired         = out_fired_q;
  assign res_o.fired_tag     = out_tag_q;
  assign res_o.fired_time    = out_time_q;
  assign res_o.rejected      = out_rej_q;
  assign res_o.overrun_total = out_ovr_q;
  assign res_o.occupancy     = out_occ_q;

  `TESQ_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= DEPTH_C)
  `TESQ_ASSERT_NXT(a_full_reject, clk_i, rst_ni,
                   ev_i.valid && ev_i.ready && (ev_i.operation == OP_PUSH) &&
                   (cnt_q == DEPTH_C), res_rej_q && (cnt_q == DEPTH_C))
  `TESQ_ASSERT_NXT(a_fire_pops, clk_i, rst_ni, (state_q == ST_TICK_CMP) && fire,
                   cnt_q == ($past(cnt_q) - 1'b1))
  `TESQ_ASSERT_NXT(a_resp_holds, clk_i, rst_ni,
                   (state_q == ST_RESP) && out_valid_q && !res_o.ready,
                   (state_q == ST_RESP) && $stable(out_tag_q) && $stable(out_time_q))

endmodule

`default_nettype wire

// File: bench/timed_event_sorted_queue_tb.sv
// ----------------------------------------------------------------------------
// timed_event_sorted_queue_tb
// self-checking bench for the time-ordered event ring
//
// requests (push, tick, clear and the unused code) go out from a queue filled
// at start: a short directed list, then random scenarios of pushes followed by
// advancing ticks, ring-filling bursts that overrun, and fully random noise.
// a local model of the ring predicts each result, and the monitor compares
// every returned result field by field, in order. both channels idle in random
// bursts except near the end of the run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_event_sorted_queue_tb;
  import tesq_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned TW           = 40;
  localparam int unsigned GW           = 16;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 40;
  localparam int unsigned CALM_TAIL    = 100;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [TW-1:0]   TIME_MAX  = '1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [TW-1:0]   ev_time;
    logic [GW-1:0]   ev_tag;
    logic [TW-1:0]   now;
  } sched_req_t;

  typedef struct packed {
    logic             fired;
    logic [GW-1:0]    tag;
    logic [TW-1:0]    at;
    logic             rejected;
    logic [OVR_W-1:0] overruns;
    logic [OCC_W-1:0] occupancy;
  } sched_outcome_t;

  logic clk_i;
  logic rst_ni;

  tesq_in_if  #(.TIME_WIDTH(TW), .TAG_WIDTH(GW)) ev_if ();
  tesq_out_if #(.TIME_WIDTH(TW), .TAG_WIDTH(GW)) res_if ();

  timed_event_sorted_queue #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_WIDTH (TW),
    .TAG_WIDTH  (GW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ev_i  (ev_if),
    .res_o (res_if)
  );

  // model of the ring
  logic [TW-1:0]    slot_at [DEPTH];
  logic [GW-1:0]    slot_id [DEPTH];
  int unsigned      head_pos;
  int unsigned      held;
  logic [TW-1:0]    last_tick;
  logic             no_tick_yet;
  logic [OVR_W-1:0] overruns;

  sched_req_t     sched_requests[$];
  sched_outcome_t sched_outcomes[$];
  sched_req_t     nxt;
  sched_req_t     seen;
  sched_outcome_t want;

  logic        req_taken;
  int unsigned send_gap;
  int unsigned stall;
  int unsigned made;
  int unsigned errors;
  int unsigned n_push, n_tick, n_clear, n_other, n_fired, n_rejected;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void clear_schedule();
    head_pos    = 0;
    held        = 0;
    last_tick   = '0;
    no_tick_yet = 1'b1;
    overruns    = '0;
  endfunction

  function automatic sched_outcome_t schedule_step(sched_req_t r);
    sched_outcome_t o;
    int unsigned    k;
    int unsigned    j;
    logic [TW-1:0]  limit;
    o = '0;
    case (r.op)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          o.rejected = 1'b1;
          if (overruns != OVR_MAX) overruns = overruns + 1'b1;
        end else begin
          k = 0;
          while (k < held && r.ev_time >= slot_at[(head_pos + k) % DEPTH]) k++;
          for (j = held; j > k; j--) begin
            slot_at[(head_pos + j) % DEPTH] = slot_at[(head_pos + j - 1) % DEPTH];
            slot_id[(head_pos + j) % DEPTH] = slot_id[(head_pos + j - 1) % DEPTH];
          end
          slot_at[(head_pos + k) % DEPTH] = r.ev_time;
          slot_id[(head_pos + k) % DEPTH] = r.ev_tag;
          held++;
        end
      end
      OP_TICK: begin
        limit = no_tick_yet ? r.now : last_tick;
        if (held > 0 && slot_at[head_pos] < limit) begin
          o.fired  = 1'b1;
          o.tag    = slot_id[head_pos];
          o.at     = slot_at[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
        last_tick   = r.now;
        no_tick_yet = 1'b0;
      end
      OP_CLEAR: clear_schedule();
      default: begin
      end
    endcase
    o.overruns  = overruns;
    o.occupancy = OCC_W'(held);
    return o;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [TW-1:0] et, logic [GW-1:0] tag,
                               logic [TW-1:0] now);
    sched_req_t r;
    r.op      = op;
    r.ev_time = et;
    r.ev_tag  = tag;
    r.now     = now;
    sched_requests.push_back(r);
    made++;
  endtask

  function automatic logic [TW-1:0] any_time();
    return TW'({$urandom, $urandom});
  endfunction

  function automatic logic quiet();
    return sched_requests.size() < CALM_TAIL;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      if (errors < 10) $display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ev_if.valid <= 1'b0;
    end else if (ev_if.valid && !req_taken) begin
    end else if (send_gap != 0) begin
      ev_if.valid <= 1'b0;
      send_gap    <= send_gap - 1;
    end else if (sched_requests.size() != 0) begin
      nxt = sched_requests.pop_front();
      ev_if.valid        <= 1'b1;
      ev_if.operation    <= nxt.op;
      ev_if.event_time   <= nxt.ev_time;
      ev_if.event_tag    <= nxt.ev_tag;
      ev_if.current_time <= nxt.now;
      if (!quiet() && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
    end else begin
      ev_if.valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall != 0) begin
      res_if.ready <= 1'b0;
      stall        <= stall - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (!quiet() && $urandom_range(0, 9) == 0) stall <= $urandom_range(1, 17);
    end
  end

  // monitor: check results, then predict for the request taken at this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (sched_outcomes.size() == 0) begin
          if (errors < 10) $display("result with no request outstanding");
          errors++;
        end else begin
          want = sched_outcomes.pop_front();
          check_field("fired", 64'(want.fired), 64'(res_if.fired));
          check_field("fired_tag", 64'(want.tag), 64'(res_if.fired_tag));
          check_field("fired_time", 64'(want.at), 64'(res_if.fired_time));
          check_field("rejected", 64'(want.rejected), 64'(res_if.rejected));
          check_field("overrun_total", 64'(want.overruns), 64'(res_if.overrun_total));
          check_field("occupancy", 64'(want.occupancy), 64'(res_if.occupancy));
          n_fired    += want.fired;
          n_rejected += want.rejected;
        end
      end
      if (ev_if.valid && ev_if.ready) begin
        seen.op      = ev_if.operation;
        seen.ev_time = ev_if.event_time;
        seen.ev_tag  = ev_if.event_tag;
        seen.now     = ev_if.current_time;
        sched_outcomes.push_back(schedule_step(seen));
        case (seen.op)
          OP_PUSH:  n_push++;
          OP_TICK:  n_tick++;
          OP_CLEAR: n_clear++;
          default:  n_other++;
        endcase
      end
      req_taken <= ev_if.valid && ev_if.ready;
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [TW-1:0] base;
    logic [TW-1:0] last;
    int unsigned   pick;
    int unsigned   n;
    rst_ni             = 1'b0;
    ev_if.valid        = 1'b0;
    ev_if.operation    = '0;
    ev_if.event_time   = '0;
    ev_if.event_tag    = '0;
    ev_if.current_time = '0;
    res_if.ready       = 1'b0;
    send_gap = 0;
    stall    = 0;
    errors   = 0;
    made     = 0;
    n_push = 0; n_tick = 0; n_clear = 0; n_other = 0; n_fired = 0; n_rejected = 0;
    clear_schedule();

    queue_request(OP_TICK, '0, '0, '0);
    queue_request(OP_PUSH, TIME_MAX, '1, '0);
    queue_request(OP_PUSH, '0, '0, TIME_MAX);
    queue_request(OP_PUSH, 40'd100, 16'd1, '0);
    queue_request(OP_PUSH, 40'd100, 16'd2, '0);
    queue_request(OP_UNUSED, TIME_MAX, '1, TIME_MAX);
    queue_request(OP_TICK, TIME_MAX, '1, 40'd50);
    queue_request(OP_TICK, '0, '0, 40'd200);
    queue_request(OP_TICK, '0, '0, 40'd200);
    queue_request(OP_TICK, '0, '0, '0);
    queue_request(OP_TICK, '0, '0, TIME_MAX);
    queue_request(OP_TICK, '0, '0, TIME_MAX);
    queue_request(OP_CLEAR, TIME_MAX, '1, TIME_MAX);
    queue_request(OP_PUSH, 40'd500, 16'd7, '0);
    queue_request(OP_TICK, '0, '0, 40'd501);
    queue_request(OP_PUSH, 40'h55_5555_5555, 16'h5555, 40'hAA_AAAA_AAAA);
    queue_request(OP_PUSH, 40'hAA_AAAA_AAAA, 16'hAAAA, 40'h55_5555_5555);
    queue_request(OP_TICK, '0, '0, TIME_MAX);
    queue_request(OP_TICK, '0, '0, TIME_MAX);
    queue_request(OP_CLEAR, '0, '0, '0);
    queue_request(OP_UNUSED, '0, '0, '0);

    made = 0;
    base = 40'd1000;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // overfill, usually with the head somewhere mid-ring
        n = $urandom_range(66, 72);
        repeat (n) begin
          base += $urandom_range(0, 3);
          queue_request(OP_PUSH, base + $urandom_range(0, 500), GW'($urandom), any_time());
        end
        repeat ($urandom_range(2, 10)) begin
          base += $urandom_range(10, 200);
          queue_request(OP_TICK, any_time(), GW'($urandom), base);
        end
      end else if (pick < 80) begin
        if ($urandom_range(0, 3) == 0) queue_request(OP_CLEAR, any_time(), GW'($urandom), any_time());
        n    = $urandom_range(1, 12);
        last = base;
        repeat (n) begin
          if ($urandom_range(0, 3) != 0) last = base + $urandom_range(0, 400);
          queue_request(OP_PUSH, last, GW'($urandom), any_time());
        end
        repeat (n + $urandom_range(0, 4)) begin
          base += $urandom_range(0, 120);
          queue_request(OP_TICK, any_time(), GW'($urandom), base);
        end
        if ($urandom_range(0, 15) == 0) base = any_time();
      end else begin
        repeat ($urandom_range(1, 6))
          queue_request(OP_W'($urandom_range(0, 3)), any_time(), GW'($urandom), any_time());
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (sched_requests.size() != 0 || ev_if.valid || sched_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d pushes, %0d ticks, %0d clears, %0d unused-code requests",
             n_push, n_tick, n_clear, n_other);
    $display("%0d events fired, %0d pushes turned away by a full ring, %0d mismatches",
             n_fired, n_rejected, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
